FILE: hdl/iai_pkg.sv
package iai_pkg;

  // Array geometry
  localparam int DEPTH     = 64;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int FILL_W    = $clog2(DEPTH + 1);

  // Reduction tree: first level sums groups of GRP cells
  localparam int GRP       = 8;
  localparam int NGRP      = (DEPTH + GRP - 1) / GRP;
  localparam int GRP_CNT_W = $clog2(GRP + 1);

  // Result counts are 7 bits wide and saturate
  localparam int OUT_CNT_W = 7;
  localparam int CNT_MAX   = 127;

  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_COUNT  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RED_A,
    S_RED_B,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] index;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [31:0]          data;
    logic [OUT_CNT_W-1:0] match_count;
    logic [OUT_CNT_W-1:0] occupancy;
  } out_word_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              write;
    logic              rd_sel;
    logic              cnt_en;
    logic [IDX_W-1:0]  idx;
    elem_t             value;
    logic [FILL_W-1:0] fill;
  } cell_cmd_t;

  // Saturate a count to the 7-bit result field
  function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [FILL_W-1:0] n);
    logic [OUT_CNT_W-1:0] res;
    if (32'(n) > CNT_MAX) begin
      res = OUT_CNT_W'(CNT_MAX);
    end else begin
      res = OUT_CNT_W'(n);
    end
    return res;
  endfunction

endpackage

FILE: hdl/iai_cell.sv
module iai_cell (
  input  logic                    clk,
  input  logic [iai_pkg::IDX_W-1:0] pos,
  input  logic                    exec_en,
  input  iai_pkg::cell_cmd_t      cmd,
  input  iai_pkg::elem_t          left_word,
  input  iai_pkg::elem_t          right_word,
  output iai_pkg::elem_t          word,
  output logic                    match,
  output iai_pkg::elem_t          sel_word
);

  iai_pkg::elem_t word_r, word_nxt;
  logic           match_r, match_nxt;
  iai_pkg::elem_t sel_r, sel_nxt;
  logic           held;
  logic           at_idx;

  assign held   = iai_pkg::FILL_W'(pos) < cmd.fill;
  assign at_idx = pos == cmd.idx;

  // Entry update: take from lower neighbour, upper neighbour or the command
  always_comb begin
    word_nxt = word_r;
    if (exec_en) begin
      priority if (cmd.shift_up) begin
        if (at_idx) begin
          word_nxt = cmd.value;
        end else if (pos > cmd.idx) begin
          word_nxt = left_word;
        end
      end else if (cmd.shift_down) begin
        if (pos >= cmd.idx) begin
          word_nxt = right_word;
        end
      end else if (cmd.write) begin
        if (at_idx) begin
          word_nxt = cmd.value;
        end
      end else begin
        // read-only ops leave the entry alone
        word_nxt = word_r;
      end
    end
  end

  // Per-cell compare and read select, taken from the old contents
  always_comb begin
    match_nxt = match_r;
    sel_nxt   = sel_r;
    if (exec_en) begin
      match_nxt = cmd.cnt_en && held && (word_r == cmd.value);
      sel_nxt   = (cmd.rd_sel && at_idx) ? word_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    match_r <= match_nxt;
    sel_r   <= sel_nxt;
  end

  assign word     = word_r;
  assign match    = match_r;
  assign sel_word = sel_r;

endmodule

FILE: hdl/iai_reduce.sv
module iai_reduce (
  input  logic                         clk,
  input  logic [iai_pkg::DEPTH-1:0]    match_vec,
  input  iai_pkg::elem_t               sel_words [iai_pkg::DEPTH],
  output logic [iai_pkg::FILL_W-1:0]   cnt,
  output iai_pkg::elem_t               rd_word
);

  logic [iai_pkg::GRP_CNT_W-1:0] grp_cnt_r [iai_pkg::NGRP];
  logic [iai_pkg::GRP_CNT_W-1:0] grp_cnt_nxt [iai_pkg::NGRP];
  iai_pkg::elem_t                grp_or_r [iai_pkg::NGRP];
  iai_pkg::elem_t                grp_or_nxt [iai_pkg::NGRP];
  logic [iai_pkg::FILL_W-1:0]    cnt_r, cnt_nxt;
  iai_pkg::elem_t                or_r, or_nxt;

  // First level: popcount and OR over groups of cells
  always_comb begin
    int i;
    for (int g = 0; g < iai_pkg::NGRP; g++) begin
      grp_cnt_nxt[g] = '0;
      grp_or_nxt[g]  = '0;
      for (int j = 0; j < iai_pkg::GRP; j++) begin
        i = g * iai_pkg::GRP + j;
        if (i < iai_pkg::DEPTH) begin
          grp_cnt_nxt[g] = grp_cnt_nxt[g] + iai_pkg::GRP_CNT_W'(match_vec[i]);
          grp_or_nxt[g]  = grp_or_nxt[g] | sel_words[i];
        end
      end
    end
  end

  // Second level: fold the group results
  always_comb begin
    cnt_nxt = '0;
    or_nxt  = '0;
    for (int g = 0; g < iai_pkg::NGRP; g++) begin
      cnt_nxt = cnt_nxt + iai_pkg::FILL_W'(grp_cnt_r[g]);
      or_nxt  = or_nxt | grp_or_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_cnt_r <= grp_cnt_nxt;
    grp_or_r  <= grp_or_nxt;
    cnt_r     <= cnt_nxt;
    or_r      <= or_nxt;
  end

  assign cnt     = cnt_r;
  assign rd_word = or_r;

endmodule

FILE: hdl/indexed_array_insert_remove_top.sv
// Indexed array with insert and remove: an ordered store of DEPTH entries
// held in a row of cells, each cell one entry, shifting in parallel.
// Request channel: present in_word (op, index, value) with start high; the
// word is taken at a rising edge where start is high and busy is low. busy
// rises the cycle after and stays high until the result has been shown.
// Result channel: out_word (status, data, match_count, occupancy) is valid
// for exactly one cycle, marked by out_valid, in state S_RESP, which follows
// S_EXEC, S_RED_A and S_RED_B. The receiver cannot stall; the result is
// simply dropped if unused. No new request is taken before it is shown.
// S_EXEC updates every cell at once (insert/remove shifts, set writes) and latches
// per-cell compare and read-select words; S_RED_A and S_RED_B run the registered
// reduction tree that sums matches and ORs the selected word; S_RESP shows it.
// Reset (rst_n low, synchronous) empties the array and returns to idle;
// stored entries are not cleared and are only read after being written.
// Errors (remove on empty, index out of range, insert when full) leave the
// array unchanged and return data 0.
module indexed_array_insert_remove_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  iai_pkg::in_word_t  in_word,
  output logic               out_valid,
  output iai_pkg::out_word_t out_word
);

  iai_pkg::state_e              state_r, state_nxt;
  logic [iai_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  iai_pkg::cell_cmd_t           cmd_r, cmd_nxt;
  iai_pkg::status_e             status_r, status_nxt;
  logic                         accept;
  logic                         exec_en;
  logic [15:0]                  fill16;
  logic                         full;

  iai_pkg::elem_t               words [iai_pkg::DEPTH];
  iai_pkg::elem_t               sel_words [iai_pkg::DEPTH];
  logic [iai_pkg::DEPTH-1:0]    match_vec;
  logic [iai_pkg::FILL_W-1:0]   red_cnt;
  iai_pkg::elem_t               red_word;

  assign accept = start && !busy;
  assign fill16 = 16'(fill_r);
  assign full   = fill_r == iai_pkg::FILL_W'(iai_pkg::DEPTH);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iai_pkg::S_IDLE:  if (accept) state_nxt = iai_pkg::S_EXEC;
      iai_pkg::S_EXEC:  state_nxt = iai_pkg::S_RED_A;
      iai_pkg::S_RED_A: state_nxt = iai_pkg::S_RED_B;
      iai_pkg::S_RED_B: state_nxt = iai_pkg::S_RESP;
      iai_pkg::S_RESP:  state_nxt = iai_pkg::S_IDLE;
      default:          state_nxt = iai_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy      = 1'b1;
    exec_en   = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      iai_pkg::S_IDLE:  busy = 1'b0;
      iai_pkg::S_EXEC:  exec_en = 1'b1;
      iai_pkg::S_RED_A: ;
      iai_pkg::S_RED_B: ;
      iai_pkg::S_RESP:  out_valid = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  // Decode request: range checks, status, new fill and cell command
  always_comb begin
    fill_nxt   = fill_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = iai_pkg::ST_OK;
      cmd_nxt    = '0;
      cmd_nxt.idx   = iai_pkg::IDX_W'(in_word.index);
      cmd_nxt.value = iai_pkg::ELEM_BITS'(in_word.value);
      cmd_nxt.fill  = fill_r;
      unique case (iai_pkg::op_e'(in_word.op))
        iai_pkg::OP_INSERT: begin
          if (in_word.index > fill16) begin
            status_nxt = iai_pkg::ST_RANGE;
          end else if (full) begin
            status_nxt = iai_pkg::ST_FULL;
          end else begin
            cmd_nxt.shift_up = 1'b1;
            fill_nxt         = fill_r + iai_pkg::FILL_W'(1);
          end
        end
        iai_pkg::OP_REMOVE: begin
          if (fill_r == '0) begin
            status_nxt = iai_pkg::ST_EMPTY;
          end else if (in_word.index >= fill16) begin
            status_nxt = iai_pkg::ST_RANGE;
          end else begin
            cmd_nxt.shift_down = 1'b1;
            cmd_nxt.rd_sel     = 1'b1;
            fill_nxt           = fill_r - iai_pkg::FILL_W'(1);
          end
        end
        iai_pkg::OP_GET: begin
          if (in_word.index >= fill16) begin
            status_nxt = iai_pkg::ST_RANGE;
          end else begin
            cmd_nxt.rd_sel = 1'b1;
          end
        end
        iai_pkg::OP_SET: begin
          if (in_word.index >= fill16) begin
            status_nxt = iai_pkg::ST_RANGE;
          end else begin
            cmd_nxt.write = 1'b1;
          end
        end
        iai_pkg::OP_COUNT: cmd_nxt.cnt_en = 1'b1;
        iai_pkg::OP_CLEAR: fill_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iai_pkg::S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
  end

  // Row of cells, each linked to both neighbours
  for (genvar k = 0; k < iai_pkg::DEPTH; k++) begin : g_cell
    iai_pkg::elem_t left_w;
    iai_pkg::elem_t right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[k-1];
    end
    if (k == iai_pkg::DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[k+1];
    end

    iai_cell u_cell (
      .clk        (clk),
      .pos        (iai_pkg::IDX_W'(k)),
      .exec_en    (exec_en),
      .cmd        (cmd_r),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[k]),
      .match      (match_vec[k]),
      .sel_word   (sel_words[k])
    );
  end

  iai_reduce u_reduce (
    .clk       (clk),
    .match_vec (match_vec),
    .sel_words (sel_words),
    .cnt       (red_cnt),
    .rd_word   (red_word)
  );

  // Result word
  always_comb begin
    out_word.status      = status_r;
    out_word.data        = 32'(red_word);
    out_word.match_count = iai_pkg::sat_cnt(red_cnt);
    out_word.occupancy   = iai_pkg::sat_cnt(fill_r);
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import iai_pkg::*;

  // Spare op codes: the block ignores them but still answers
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RUN_LIMIT   = 500000;
  localparam int DRAIN_TAIL  = 12;
  localparam int SHOW_MAX    = 10;
  localparam int RANDOM_ITEMS = 1780;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  // Shadow copy of the array, updated as each word is taken
  elem_t       shadow_entries [DEPTH];
  int unsigned shadow_fill = 0;

  out_word_t   due_results [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;

  indexed_array_insert_remove_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAIL indexed_array_insert_remove_top");
      $finish;
    end
  end

  // Work out the result of one request and apply it to the shadow array
  function automatic out_word_t apply_request(input in_word_t w);
    out_word_t   res;
    int unsigned idx;
    int unsigned hits;
    int unsigned k;
    res  = '0;
    idx  = w.index;
    hits = 0;
    case (w.op)
      OP_INSERT: begin
        if (idx > shadow_fill) begin
          res.status = ST_RANGE;
        end else if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = shadow_fill; k > idx; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[idx] = elem_t'(w.value);
          shadow_fill++;
        end
      end
      OP_REMOVE: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (idx >= shadow_fill) begin
          res.status = ST_RANGE;
        end else begin
          res.data = 32'(shadow_entries[idx]);
          for (k = idx; k + 1 < shadow_fill; k++) shadow_entries[k] = shadow_entries[k+1];
          shadow_fill--;
        end
      end
      OP_GET: begin
        if (idx >= shadow_fill) begin
          res.status = ST_RANGE;
        end else begin
          res.data = 32'(shadow_entries[idx]);
        end
      end
      OP_SET: begin
        if (idx >= shadow_fill) begin
          res.status = ST_RANGE;
        end else begin
          shadow_entries[idx] = elem_t'(w.value);
        end
      end
      OP_COUNT: begin
        for (k = 0; k < shadow_fill; k++) begin
          if (shadow_entries[k] == elem_t'(w.value)) hits++;
        end
      end
      OP_CLEAR: begin
        shadow_fill = 0;
      end
      default: ;
    endcase
    res.match_count = (hits > CNT_MAX) ? OUT_CNT_W'(CNT_MAX) : OUT_CNT_W'(hits);
    res.occupancy   = (shadow_fill > CNT_MAX) ? OUT_CNT_W'(CNT_MAX) : OUT_CNT_W'(shadow_fill);
    return res;
  endfunction

  function automatic in_word_t make_word(input logic [2:0] op, input logic [15:0] idx,
                                         input logic [31:0] val);
    in_word_t w;
    w.op    = op;
    w.index = idx;
    w.value = val;
    return w;
  endfunction

  // Idle length: mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(4, 1);
    return $urandom_range(40, 5);
  endfunction

  // Drop start for the given idle length, with junk on the word lines
  task automatic idle_for(input int n);
    if (n > 0) begin
      start   <= 1'b0;
      in_word <= in_word_t'({$urandom(), $urandom()});
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one word and hold it until the block takes it
  task automatic send_word(input in_word_t w);
    idle_for(gap_len());
    in_word <= w;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    due_results.push_back(apply_request(w));
  endtask

  // Compare each shown result with the oldest one due
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
          $display("unexpected result word at cycle %0d: %h", cycle_count, out_word);
      end else begin
        want = due_results.pop_front();
        if (out_word.status !== want.status || out_word.data !== want.data ||
            out_word.match_count !== want.match_count ||
            out_word.occupancy !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_MAX)
            $display("mismatch at cycle %0d: status %0d/%0d data %h/%h match %0d/%0d occ %0d/%0d",
                     cycle_count, want.status, out_word.status, want.data, out_word.data,
                     want.match_count, out_word.match_count, want.occupancy,
                     out_word.occupancy);
        end
      end
    end
  end

  // Random field choices, leaning on the boundaries of the current fill
  function automatic logic [15:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 16'($urandom_range(shadow_fill));
    if (r < 88) begin
      case ($urandom_range(2))
        0:       return (shadow_fill == 0) ? 16'd0 : 16'(shadow_fill - 1);
        1:       return 16'(shadow_fill);
        default: return 16'(shadow_fill + 1);
      endcase
    end
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 32'($urandom_range(3));
    if (r < 60 && shadow_fill > 0) return 32'(shadow_entries[$urandom_range(shadow_fill - 1)]);
    if (r < 66) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_op(input mix_e mix);
    int ins_pct;
    int rem_pct;
    int r;
    int s;
    ins_pct = (mix == MIX_GROW) ? 50 : (mix == MIX_SHRINK) ? 12 : 28;
    rem_pct = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 48 : 26;
    r = $urandom_range(99);
    if (r < ins_pct) return OP_INSERT;
    if (r < ins_pct + rem_pct) return OP_REMOVE;
    s = $urandom_range(99);
    if (s < 36) return OP_GET;
    if (s < 66) return OP_SET;
    if (s < 95) return OP_COUNT;
    if (s < 97) return OP_CLEAR;
    return $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
  endfunction

  // Hand-picked words: empty array errors, edges, every op
  task automatic test_directed();
    send_word(make_word(OP_REMOVE, 16'd0, 32'h0));
    send_word(make_word(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 16'd0, 32'h0));
    send_word(make_word(OP_SET, 16'd0, 32'h1234_5678));
    send_word(make_word(OP_COUNT, 16'd0, 32'h0));
    send_word(make_word(OP_INSERT, 16'd1, 32'h1));
    send_word(make_word(OP_INSERT, 16'd0, 32'h0));
    send_word(make_word(OP_INSERT, 16'd1, 32'hFFFF_FFFF));
    send_word(make_word(OP_INSERT, 16'd0, 32'h5A5A_A5A5));
    send_word(make_word(OP_INSERT, 16'd1, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 16'd0, 32'h0));
    send_word(make_word(OP_GET, 16'd3, 32'h0));
    send_word(make_word(OP_GET, 16'd4, 32'h0));
    send_word(make_word(OP_GET, 16'hFFFF, 32'h0));
    send_word(make_word(OP_SET, 16'd2, 32'hFFFF_FFFF));
    send_word(make_word(OP_SET, 16'hFFFF, 32'h0));
    send_word(make_word(OP_COUNT, 16'd0, 32'hFFFF_FFFF));
    send_word(make_word(OP_COUNT, 16'hFFFF, 32'h0));
    send_word(make_word(OP_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_SPARE_7, 16'd0, 32'h0));
    send_word(make_word(OP_REMOVE, 16'd1, 32'h0));
    send_word(make_word(OP_REMOVE, 16'(shadow_fill - 1), 32'h0));
    send_word(make_word(OP_REMOVE, 16'(shadow_fill), 32'h0));
    send_word(make_word(OP_INSERT, 16'hFFFF, 32'h0));
    send_word(make_word(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 16'd0, 32'h0));
    send_word(make_word(OP_REMOVE, 16'd0, 32'h0));
  endtask

  // Fill to capacity by pushes, poke the full edge, then drain
  task automatic test_full();
    logic [31:0] v;
    send_word(make_word(OP_CLEAR, 16'd0, 32'h0));
    while (shadow_fill < DEPTH) send_word(make_word(OP_INSERT, 16'(shadow_fill), pick_value()));
    send_word(make_word(OP_INSERT, 16'(DEPTH), $urandom()));
    send_word(make_word(OP_INSERT, 16'd0, $urandom()));
    send_word(make_word(OP_INSERT, 16'(DEPTH + 1), $urandom()));
    v = 32'(shadow_entries[0]);
    send_word(make_word(OP_COUNT, 16'd0, v));
    send_word(make_word(OP_GET, 16'(DEPTH - 1), 32'h0));
    send_word(make_word(OP_SET, 16'(DEPTH - 1), v));
    send_word(make_word(OP_GET, 16'(DEPTH), 32'h0));
    send_word(make_word(OP_REMOVE, 16'(DEPTH - 1), 32'h0));
    send_word(make_word(OP_INSERT, 16'd0, 32'hFFFF_FFFF));
    send_word(make_word(OP_REMOVE, 16'd0, 32'h0));
    while (shadow_fill > 0) send_word(make_word(OP_REMOVE, pick_index(), 32'h0));
    send_word(make_word(OP_REMOVE, 16'd0, 32'h0));
  endtask

  // Random traffic in segments, each with its own op mix and idle style
  task automatic test_random(input int n_items);
    mix_e mix;
    mix = MIX_EVEN;
    for (int i = 0; i < n_items; i++) begin
      if (i % 80 == 0) begin
        mix     = mix_e'($urandom_range(2));
        gaps_on = ($urandom_range(3) != 0);
      end
      send_word(make_word(pick_op(mix), pick_index(), pick_value()));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full();
    test_random(RANDOM_ITEMS);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS indexed_array_insert_remove_top");
    end else begin
      $display("FAIL indexed_array_insert_remove_top");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/iai_pkg.sv
hdl/iai_cell.sv
hdl/iai_reduce.sv
hdl/indexed_array_insert_remove_top.sv
tb/testbench.sv
